// File: src/urav_pkg.sv
// Shared types and constants for the ultrasonic range averaging block.
`default_nettype none

package urav_pkg;

  // Width of the averaged distance in Q9.8 centimetres.
  localparam int unsigned AVG_W = 17;

  // Microseconds of echo per centimetre of range.
  localparam int unsigned US_PER_CM = 58;

  // Configuration address width and register indexes.
  localparam int unsigned CFG_AW = 4;
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_TRIGGER = 2'd1;
  localparam logic [1:0] REG_SAMPLES = 2'd2;
  localparam logic [1:0] REG_STOP    = 2'd3;

  // Register reset values.
  localparam logic [13:0] TIMEOUT_RST = 14'd12000;
  localparam logic [7:0]  TRIGGER_RST = 8'd20;
  localparam logic [4:0]  SAMPLES_RST = 5'd5;
  localparam logic [7:0]  STOP_RST    = 8'd20;

  // Measurement phase.
  typedef enum logic [2:0] {
    PH_TRIGGER = 3'b001,
    PH_WAIT    = 3'b010,
    PH_MEASURE = 3'b100
  } phase_e;

  // Top-level sequencing: take ticks, or wait on the divider.
  typedef enum logic [1:0] {
    CTL_IDLE = 2'b01,
    CTL_DIV  = 2'b10
  } ctl_e;

  // One result item; the lowest field sits in the lowest bit.
  typedef struct packed {
    logic             drive_enable;
    logic [AVG_W-1:0] avg_distance_q8;
    logic             avg_valid;
    logic             attempt_dropped;
    logic             trig_level;
  } result_t;

endpackage

`default_nettype wire

// File: src/urav_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module urav_div #(
  parameter int unsigned NUM_W = 27,
  parameter int unsigned DEN_W = 11
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  // One step: shift in the next dividend bit and try to subtract.
  always_comb begin
    rem_sh  = {rem_q, num_q[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
    rem_d   = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    num_d   = {num_q[NUM_W-2:0], ge};
  end

  // Control: count the steps and flag the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register collects quotient bits from the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire

// File: src/ultrasonic_range_average_stop.sv
// Ultrasonic ranger: trigger, echo timing, averaging and stop distance.
// Each accepted tick yields one registered result; a tick that closes an
// average waits for the bit-serial divider before its result is written.
// Throughput: one tick per cycle unless the output is stalled or the divider is busy.
// Reset (rst_ni low, asynchronous): registers at defaults, trigger phase,
// sums and average cleared, drive enabled, no result pending.
`default_nettype none

module ultrasonic_range_average_stop #(
  parameter int unsigned TIMER_BITS  = 14,
  parameter int unsigned MAX_SAMPLES = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // APB configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [urav_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  // Input ticks
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [7:0]                 s_axis_tdata,  // [0] echo_level
  // Results
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // [0] trig_level, [1] attempt_dropped, [2] avg_valid,
  // [19:3] avg_distance_q8, [20] drive_enable
  output logic [23:0]                     m_axis_tdata
);

  import urav_pkg::*;

  localparam int unsigned CNT_W     = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W     = TIMER_BITS + CNT_W;
  localparam int unsigned NUM_W     = SUM_W + 8;
  localparam int unsigned DEN_W     = CNT_W + 6;
  localparam int unsigned TIMER_MAX = (1 << TIMER_BITS) - 1;

  // Configuration registers
  logic [13:0] timeout_q;
  logic [7:0]  trigger_q;
  logic [4:0]  samples_q;
  logic [7:0]  stop_q;

  // Measurement state
  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] tick_q, tick_d;
  logic [CNT_W-1:0]      gs_q, gs_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [AVG_W-1:0]      last_avg_q;
  logic                  halted_q;
  ctl_e                  ctl_q;

  // Output stage
  logic    out_valid_q;
  result_t out_q;
  result_t res;

  // Step helpers
  logic                  echo;
  logic                  in_acc;
  logic [TIMER_BITS-1:0] limit;
  logic [CNT_W-1:0]      need;
  logic [7:0]            trig_len;
  logic [TIMER_BITS:0]   tick_inc;
  logic [SUM_W-1:0]      sum_new;
  logic [CNT_W-1:0]      gs_new;
  logic                  div_start;
  logic [NUM_W-1:0]      div_num;
  logic [DEN_W-1:0]      div_den;
  logic                  div_done;
  logic [NUM_W-1:0]      div_quot;
  logic [AVG_W-1:0]      avg_new;

  assign pready = 1'b1;
  assign echo   = s_axis_tdata[0];

  // Register writes and reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      trigger_q <= TRIGGER_RST;
      samples_q <= SAMPLES_RST;
      stop_q    <= STOP_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_TIMEOUT: timeout_q <= pwdata[13:0];
        REG_TRIGGER: trigger_q <= pwdata[7:0];
        REG_SAMPLES: samples_q <= pwdata[4:0];
        REG_STOP:    stop_q    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TIMEOUT: prdata = {18'd0, timeout_q};
      REG_TRIGGER: prdata = {24'd0, trigger_q};
      REG_SAMPLES: prdata = {27'd0, samples_q};
      REG_STOP:    prdata = {24'd0, stop_q};
      default:     prdata = '0;
    endcase
  end

  // Effective limits from the registers
  always_comb begin
    if (32'(timeout_q) > TIMER_MAX) limit = TIMER_BITS'(TIMER_MAX);
    else                            limit = TIMER_BITS'(timeout_q);
    if (samples_q == 5'd0)                      need = CNT_W'(1);
    else if (32'(samples_q) > MAX_SAMPLES)      need = CNT_W'(MAX_SAMPLES);
    else                                        need = CNT_W'(samples_q);
    trig_len = (trigger_q == 8'd0) ? 8'd1 : trigger_q;
  end

  // One tick of the measurement sequence
  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    gs_d      = gs_q;
    sum_d     = sum_q;
    div_start = 1'b0;
    tick_inc  = {1'b0, tick_q} + 1'b1;
    sum_new   = sum_q + SUM_W'(tick_q);
    gs_new    = gs_q + 1'b1;
    div_num   = {sum_new, 8'h00};
    div_den   = DEN_W'(US_PER_CM) * DEN_W'(gs_new);
    res                 = '0;
    res.avg_distance_q8 = last_avg_q;
    res.drive_enable    = !halted_q;
    if (!halted_q) begin
      case (phase_q)
        PH_TRIGGER: begin
          res.trig_level = 1'b1;
          if (tick_inc >= (TIMER_BITS+1)'(trig_len)) begin
            phase_d = PH_WAIT;
            tick_d  = '0;
          end else begin
            tick_d = tick_inc[TIMER_BITS-1:0];
          end
        end
        PH_WAIT: begin
          if (echo) begin
            phase_d = PH_MEASURE;
            tick_d  = TIMER_BITS'(1);
          end else if (tick_q >= limit) begin
            res.attempt_dropped = 1'b1;
            phase_d             = PH_TRIGGER;
            tick_d              = '0;
          end else begin
            tick_d = tick_inc[TIMER_BITS-1:0];
          end
        end
        PH_MEASURE: begin
          if (echo) begin
            if (tick_q >= limit) begin
              res.attempt_dropped = 1'b1;
              phase_d             = PH_TRIGGER;
              tick_d              = '0;
            end else begin
              tick_d = tick_inc[TIMER_BITS-1:0];
            end
          end else begin
            phase_d = PH_TRIGGER;
            tick_d  = '0;
            if (gs_new >= need) begin
              div_start = in_acc;
              gs_d      = '0;
              sum_d     = '0;
            end else begin
              gs_d  = gs_new;
              sum_d = sum_new;
            end
          end
        end
        default: begin
          phase_d = PH_TRIGGER;
          tick_d  = '0;
        end
      endcase
    end
  end

  // Averaging divide: sum * 256 / (58 * count)
  urav_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign avg_new = div_quot[AVG_W-1:0];

  // Handshakes: a new tick enters once the divider is idle and the output slot frees up
  assign s_axis_tready = (ctl_q == CTL_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q};

  // Sequencing and state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= CTL_IDLE;
      phase_q     <= PH_TRIGGER;
      tick_q      <= '0;
      gs_q        <= '0;
      sum_q       <= '0;
      last_avg_q  <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      case (ctl_q)
        CTL_IDLE: begin
          if (in_acc) begin
            phase_q <= phase_d;
            tick_q  <= tick_d;
            gs_q    <= gs_d;
            sum_q   <= sum_d;
            if (div_start) begin
              ctl_q <= CTL_DIV;
            end else begin
              out_valid_q <= 1'b1;
            end
          end
        end
        CTL_DIV: begin
          if (div_done) begin
            ctl_q       <= CTL_IDLE;
            last_avg_q  <= avg_new;
            halted_q    <= avg_new <= AVG_W'({stop_q, 8'h00});
            out_valid_q <= 1'b1;
          end
        end
        default: ctl_q <= CTL_IDLE;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (ctl_q == CTL_IDLE && in_acc && !div_start) begin
      out_q <= res;
    end else if (ctl_q == CTL_DIV && div_done) begin
      out_q.trig_level      <= 1'b0;
      out_q.attempt_dropped <= 1'b0;
      out_q.avg_valid       <= 1'b1;
      out_q.avg_distance_q8 <= avg_new;
      out_q.drive_enable    <= !(avg_new <= AVG_W'({stop_q, 8'h00}));
    end
  end

endmodule

`default_nettype wire
